@@ src/afifo_pkg.sv @@
// Shared types, constants and the float-to-int16 conversion for the audio frame FIFO.
package afifo_pkg;

   localparam int DefCapacity    = 4096;
   localparam int DefMaxChannels = 8;
   localparam int CntWidth       = 48;
   localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] KIND_PUSH_OK   = 2'd0;
   localparam logic [1:0] KIND_PUSH_DROP = 2'd1;
   localparam logic [1:0] KIND_SAMPLE    = 2'd2;
   localparam logic [1:0] KIND_POP_EMPTY = 2'd3;

   localparam logic [0:0] CSR_NUM_CHANNELS  = 1'b0;
   localparam logic [0:0] CSR_OUTPUT_FORMAT = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [31:0] sample_0;
      logic [31:0] sample_1;
      logic [31:0] sample_2;
      logic [31:0] sample_3;
      logic [31:0] sample_4;
      logic [31:0] sample_5;
      logic [31:0] sample_6;
      logic [31:0] sample_7;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [31:0]         sample_out;
      logic [2:0]          channel;
      logic                last;
      logic                overrun;
      logic [CntWidth-1:0] samples_written;
      logic [CntWidth-1:0] samples_dropped;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;       // capture request word
      logic       decide;     // register fit/empty checks
      logic       wr_en;      // write one sample
      logic       rd_en;      // read one sample
      logic [2:0] idx;        // channel index of the step
      logic       push_done;  // commit push pointers and counters
      logic       drop;       // commit drop
      logic       pop_done;   // advance read pointer
      logic       conv;       // register converted read data
      logic       out_ld;     // load output register
      logic [1:0] out_kind;
      logic       out_last;
   } afifo_cmd_type;

   typedef struct packed {
      logic       is_pop;
      logic       fits;
      logic       has_frame;
      logic [3:0] nc;
   } afifo_sts_type;

   // Clamp to [-1,1], scale by 32767, truncate toward zero; NaN gives zero.
   // The product is first rounded to a 24-bit significand, ties to even, as a
   // float multiply does, since that rounding can carry into the integer part.
   function automatic logic [31:0] to_s16(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [23:0] m;
      logic [39:0] p;
      logic [39:0] pr;
      logic        up;
      logic [15:0] mag;
      logic [31:0] r;
      s = f[31];
      e = f[30:23];
      m = {1'b1, f[22:0]};
      p = 40'(m) * 40'd32767;
      // Round the product to 24 significant bits
      if (p[38]) begin
         up = p[14] && (p[15] || (p[13:0] != '0));
         pr = {p[39:15], 15'd0} + (up ? 40'h8000 : 40'd0);
      end else begin
         up = p[13] && (p[14] || (p[12:0] != '0));
         pr = {p[39:14], 14'd0} + (up ? 40'h4000 : 40'd0);
      end
      mag = '0;
      if (e == 8'hFF && f[22:0] != 0) begin
         mag = '0;
      end else if (e >= 8'd127) begin
         mag = 16'd32767;
      end else if (e >= 8'd103) begin
         // value = m*2^(e-150); product shifted by (150-e), range 24..47
         mag = 16'(pr >> (8'd150 - e));
      end else begin
         mag = '0;
      end
      r = s ? (32'd0 - 32'(mag)) : 32'(mag);
      return r;
   endfunction

endpackage

@@ src/afifo_ctrl.sv @@
// Controller sequencing push writes, pop reads and result delivery.
module afifo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    rsp_stall,
   input  logic                    out_full,
   input  afifo_pkg::afifo_sts_type sts,
   output afifo_pkg::afifo_cmd_type cmd
);
   import afifo_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_WR   = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_CV   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [2:0] S_SGL  = 3'd6;
   localparam logic [2:0] S_BR   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic [1:0] kind_ff, kind_in;
   logic       free;

   assign free = !out_full || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Sequence one word through its steps
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_BR;
         end
         // Branch on the registered fit and frame checks
         S_BR: begin
            idx_in = '0;
            if (!sts.is_pop) begin
               state_in = sts.fits ? S_WR : S_SGL;
               kind_in  = sts.fits ? KIND_PUSH_OK : KIND_PUSH_DROP;
               if (!sts.fits) cmd.drop = 1'b1;
            end else if (sts.has_frame) begin
               state_in = S_RD;
            end else begin
               state_in = S_SGL;
               kind_in  = KIND_POP_EMPTY;
            end
         end
         S_WR: begin
            cmd.wr_en = 1'b1;
            if ({1'b0, idx_ff} == sts.nc - 4'd1) begin
               cmd.push_done = 1'b1;
               state_in = S_SGL;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in = S_CV;
         end
         S_CV: begin
            cmd.conv = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_kind = KIND_SAMPLE;
               cmd.out_last = ({1'b0, idx_ff} == sts.nc - 4'd1);
               if (cmd.out_last) begin
                  cmd.pop_done = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  state_in = S_RD;
               end
            end
         end
         S_SGL: begin
            if (free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_kind = kind_ff;
               cmd.out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end
endmodule

@@ src/afifo_dp.sv @@
// Datapath: sample ring memory, pointers, counters, conversion and output register.
module afifo_dp #(
   parameter int CAPACITY     = afifo_pkg::DefCapacity,
   parameter int MAX_CHANNELS = afifo_pkg::DefMaxChannels
) (
   input  logic                     clock,
   input  logic                     reset,
   input  afifo_pkg::req_word_type  req_data,
   input  logic [3:0]               num_channels,
   input  logic                     output_format,
   input  afifo_pkg::afifo_cmd_type cmd,
   output afifo_pkg::afifo_sts_type sts,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output afifo_pkg::rsp_word_type  rsp_data
);
   import afifo_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic [31:0]   mem [CAPACITY];
   logic [AW-1:0] wptr_ff, rptr_ff;
   logic          ovr_ff;
   logic [CntWidth-1:0] wcnt_ff, dcnt_ff;
   req_word_type  req_ff;
   logic [3:0]    nc_ff;
   logic          fits_ff, frame_ff;
   logic [31:0]   rd_ff, cv_ff;
   logic          fmt_ff;
   logic          vld_ff;
   rsp_word_type  out_ff;
   logic [3:0]    nc;
   logic [AW-1:0] used;
   logic [AW:0]   avail;
   logic [31:0]   wsel;
   logic [CntWidth:0] wsum, dsum;

   // Clamp channel count to 1..MAX_CHANNELS
   always_comb begin
      if (num_channels == 4'd0) nc = 4'd1;
      else if (num_channels > 4'(MAX_CHANNELS)) nc = 4'(MAX_CHANNELS);
      else nc = num_channels;
   end

   assign used  = wptr_ff - rptr_ff;
   assign avail = (AW+1)'(CAPACITY) - {1'b0, used} - (AW+1)'(1);

   assign sts.is_pop    = req_ff.opcode;
   assign sts.fits      = fits_ff;
   assign sts.has_frame = frame_ff;
   assign sts.nc        = nc_ff;

   // Pick the sample for the current write step
   always_comb begin
      case (cmd.idx)
         3'd0: wsel = req_ff.sample_0;
         3'd1: wsel = req_ff.sample_1;
         3'd2: wsel = req_ff.sample_2;
         3'd3: wsel = req_ff.sample_3;
         3'd4: wsel = req_ff.sample_4;
         3'd5: wsel = req_ff.sample_5;
         3'd6: wsel = req_ff.sample_6;
         default: wsel = req_ff.sample_7;
      endcase
   end

   assign wsum = {1'b0, wcnt_ff} + (CntWidth+1)'(nc_ff);
   assign dsum = {1'b0, dcnt_ff} + (CntWidth+1)'(nc_ff);

   // Ring memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[wptr_ff + AW'(cmd.idx)] <= wsel;
      if (cmd.rd_en) rd_ff <= mem[rptr_ff + AW'(cmd.idx)];
   end

   // Capture word, decisions and conversion
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         nc_ff  <= nc;
         fmt_ff <= output_format;
      end
      if (cmd.decide) begin
         fits_ff  <= ((AW+1)'(nc_ff) <= avail);
         frame_ff <= ((AW+1)'(nc_ff) <= {1'b0, used});
      end
      if (cmd.conv) cv_ff <= fmt_ff ? to_s16(rd_ff) : rd_ff;
   end

   // Pointers, flag and saturating counters
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         ovr_ff  <= 1'b0;
         wcnt_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.push_done) begin
            wptr_ff <= wptr_ff + AW'(nc_ff);
            wcnt_ff <= wsum[CntWidth] ? CntMax : wsum[CntWidth-1:0];
         end
         if (cmd.drop) begin
            ovr_ff  <= 1'b1;
            dcnt_ff <= dsum[CntWidth] ? CntMax : dsum[CntWidth-1:0];
         end
         if (cmd.pop_done) rptr_ff <= rptr_ff + AW'(nc_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         vld_ff <= 1'b0;
      end
      if (cmd.out_ld) begin
         out_ff.kind       <= cmd.out_kind;
         out_ff.sample_out <= (cmd.out_kind == KIND_SAMPLE) ? cv_ff : 32'd0;
         out_ff.channel    <= (cmd.out_kind == KIND_SAMPLE) ? cmd.idx : 3'd0;
         out_ff.last       <= cmd.out_last;
         out_ff.overrun    <= ovr_ff;
         out_ff.samples_written <= wcnt_ff;
         out_ff.samples_dropped <= dcnt_ff;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = out_ff;
endmodule

@@ src/audio_frame_fifo_with_format_convert.sv @@
// Sequence per accepted word: decide, branch, then a write step per channel for a push,
// or read, convert and output steps per channel for a pop; drops and empty pops go
// straight to one result. One word at a time: the input stalls until the word's last
// result is loaded into the output register, which waits while the output is held.
// Reset: synchronous, clears pointers, counters, overrun flag and registers to
// two channels, float output. Memory contents are not cleared.
module audio_frame_fifo_with_format_convert #(
   parameter int CAPACITY     = afifo_pkg::DefCapacity,
   parameter int MAX_CHANNELS = afifo_pkg::DefMaxChannels
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  afifo_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output afifo_pkg::rsp_word_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [0:0]              csr_index,
   input  logic [3:0]              csr_wdata
);
   import afifo_pkg::*;

   logic [3:0]    nch_ff;
   logic          fmt_ff;
   afifo_cmd_type cmd;
   afifo_sts_type sts;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff <= 4'd2;
         fmt_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_CHANNELS:  nch_ff <= csr_wdata;
            CSR_OUTPUT_FORMAT: fmt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   afifo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_stall(rsp_stall), .out_full(rsp_valid), .sts(sts), .cmd(cmd)
   );

   afifo_dp #(.CAPACITY(CAPACITY), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .num_channels(nch_ff),
      .output_format(fmt_ff), .cmd(cmd), .sts(sts), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule

@@ src/afifo_checker.sv @@
// Port-level checks for the audio frame FIFO, bound to the top level.
module afifo_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input afifo_pkg::rsp_word_type rsp_data
);
   import afifo_pkg::*;

   // Held result stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // Overrun flag never falls outside reset
   a_ovr: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid) && rsp_valid && $past(rsp_data.overrun) |-> rsp_data.overrun)
      else $error("overrun flag cleared");

   // Non-sample results are single and carry zero payload
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_SAMPLE |->
         rsp_data.last && rsp_data.sample_out == 32'd0 && rsp_data.channel == 3'd0)
      else $error("bad single result");

   // Accepting a word closes the input until its work is done
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input reopened at once");
endmodule

bind audio_frame_fifo_with_format_convert afifo_checker u_afifo_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

@@ tb/sv/audio_frame_fifo_with_format_convert_test.sv @@
// Self-checking testbench for the interleaving audio frame FIFO with format conversion.
`timescale 1ns / 1ps

module audio_frame_fifo_with_format_convert_test;
   import afifo_pkg::*;

   localparam int RING_WORDS = 4096;
   localparam logic [11:0] RING_MASK = 12'hFFF;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = CSR_NUM_CHANNELS;
   logic [3:0]   csr_wdata = '0;

   // Mirror of the block's state
   logic [31:0]         ring_mirror [RING_WORDS];
   logic [11:0]         wr_ptr, rd_ptr;
   logic                overrun_seen;
   logic [CntWidth-1:0] written_total, dropped_total;
   logic [3:0]          chan_reg;
   logic                int16_mode;

   rsp_word_type expected_rsp_q[$];
   int  err_count = 0;
   int  words_sent = 0;
   int  results_seen = 0;
   int  drops_seen = 0;
   int  hold_left = 0;
   int  hold_asked = 0;
   int  hold_taken = 0;
   bit  gaps_on = 1'b1;
   bit  stall_on = 1'b1;

   audio_frame_fifo_with_format_convert DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Effective channels per frame
   function automatic int frame_len();
      if (chan_reg == 4'd0) return 1;
      if (chan_reg > 4'd8) return 8;
      return int'(chan_reg);
   endfunction

   function automatic int ring_used();
      return int'((wr_ptr - rd_ptr) & RING_MASK);
   endfunction

   function automatic logic [31:0] sample_of(req_word_type w, int ch);
      case (ch)
         0: return w.sample_0;
         1: return w.sample_1;
         2: return w.sample_2;
         3: return w.sample_3;
         4: return w.sample_4;
         5: return w.sample_5;
         6: return w.sample_6;
         default: return w.sample_7;
      endcase
   endfunction

   function automatic logic [CntWidth-1:0] sat_sum(logic [CntWidth-1:0] a, int n);
      logic [CntWidth:0] s;
      s = {1'b0, a} + (CntWidth+1)'(n);
      return s[CntWidth] ? CntMax : s[CntWidth-1:0];
   endfunction

   // Clamp, scale by 32767 with float rounding of the product, truncate to zero
   function automatic logic [31:0] int16_from_float_bits(logic [31:0] f);
      logic [7:0]  ex;
      logic [63:0] prod, q, rem, half;
      int          msb, drop, ex_eff, sh;
      logic [31:0] mag;
      ex = f[30:23];
      if (ex == 8'hFF && f[22:0] != 0) return 32'd0;
      if (ex >= 8'd127) begin
         mag = 32'd32767;
      end else begin
         prod = 64'({(ex != 0), f[22:0]}) * 64'd32767;
         ex_eff = (ex == 0) ? 1 : int'(ex);
         msb = -1;
         for (int i = 0; i < 64; i++) if (prod[i]) msb = i;
         if (msb >= 24) begin
            drop = msb - 23;
            q = prod >> drop;
            rem = prod & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
            prod = q << drop;
         end
         sh = 150 - ex_eff;
         mag = (sh >= 64) ? 32'd0 : 32'(prod >> sh);
      end
      return f[31] ? (32'd0 - mag) : mag;
   endfunction

   // Work out the results of one accepted word
   task automatic predict_word(req_word_type w);
      int           nc;
      rsp_word_type r;
      logic [31:0]  raw;
      nc = frame_len();
      r = '0;
      r.last = 1'b1;
      if (w.opcode == OP_PUSH) begin
         if (nc <= RING_WORDS - 1 - ring_used()) begin
            for (int ch = 0; ch < nc; ch++)
               ring_mirror[(wr_ptr + 12'(ch)) & RING_MASK] = sample_of(w, ch);
            wr_ptr = (wr_ptr + 12'(nc)) & RING_MASK;
            written_total = sat_sum(written_total, nc);
            r.kind = KIND_PUSH_OK;
         end else begin
            overrun_seen = 1'b1;
            dropped_total = sat_sum(dropped_total, nc);
            r.kind = KIND_PUSH_DROP;
            drops_seen++;
         end
         r.overrun = overrun_seen;
         r.samples_written = written_total;
         r.samples_dropped = dropped_total;
         expected_rsp_q.push_back(r);
      end else if (ring_used() < nc) begin
         r.kind = KIND_POP_EMPTY;
         r.overrun = overrun_seen;
         r.samples_written = written_total;
         r.samples_dropped = dropped_total;
         expected_rsp_q.push_back(r);
      end else begin
         for (int ch = 0; ch < nc; ch++) begin
            raw = ring_mirror[(rd_ptr + 12'(ch)) & RING_MASK];
            r.kind = KIND_SAMPLE;
            r.sample_out = int16_mode ? int16_from_float_bits(raw) : raw;
            r.channel = 3'(ch);
            r.last = (ch == nc - 1);
            r.overrun = overrun_seen;
            r.samples_written = written_total;
            r.samples_dropped = dropped_total;
            expected_rsp_q.push_back(r);
         end
         rd_ptr = (rd_ptr + 12'(nc)) & RING_MASK;
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s at %0t: got %0h expected %0h", what, $realtime, got, want);
      err_count++;
   endtask

   // Offer one word, hold it until taken, then maybe idle
   task automatic send_word(req_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_word(w);
      words_sent++;
      gap = 0;
      if (gaps_on) begin
         case ($urandom_range(0, 19))
            0:          gap = $urandom_range(10, 40);
            1, 2, 3, 4: gap = $urandom_range(1, 3);
            default:    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_word_type random_word(logic op);
      req_word_type w;
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 1'b0};
      w.opcode = op;
      return w;
   endfunction

   task automatic push_frame(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                             logic [31:0] s3, logic [31:0] s4, logic [31:0] s5,
                             logic [31:0] s6, logic [31:0] s7);
      req_word_type w;
      w = '{OP_PUSH, s0, s1, s2, s3, s4, s5, s6, s7};
      send_word(w);
   endtask

   task automatic pop_frame();
      send_word(random_word(OP_POP));
   endtask

   // Pause the sender until every result is in, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register, then let the port go idle
   task automatic write_reg(logic [0:0] idx, logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NUM_CHANNELS) chan_reg = value;
      else int16_mode = value[0];
      @(posedge clock);
   endtask

   // Check each accepted result against the oldest expectation; stall at random
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data.kind), 64'hx);
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_data.kind !== e.kind) report_mismatch("kind", rsp_data.kind, e.kind);
            if (rsp_data.sample_out !== e.sample_out)
               report_mismatch("sample_out", rsp_data.sample_out, e.sample_out);
            if (rsp_data.channel !== e.channel)
               report_mismatch("channel", rsp_data.channel, e.channel);
            if (rsp_data.last !== e.last) report_mismatch("last", rsp_data.last, e.last);
            if (rsp_data.overrun !== e.overrun)
               report_mismatch("overrun", rsp_data.overrun, e.overrun);
            if (rsp_data.samples_written !== e.samples_written)
               report_mismatch("samples_written", rsp_data.samples_written,
                               e.samples_written);
            if (rsp_data.samples_dropped !== e.samples_dropped)
               report_mismatch("samples_dropped", rsp_data.samples_dropped,
                               e.samples_dropped);
         end
      end
      if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 39))
            0:               hold_left <= $urandom_range(8, 30);
            1, 2, 3, 4, 5:   rsp_stall <= 1'b1;
            default:         rsp_stall <= 1'b0;
         endcase
      end
   end

   // Pop on empty, then the extreme sample values through two channels
   task automatic test_reset_state();
      pop_frame();
      push_frame(32'h0000_0000, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
      push_frame(32'hAAAA_5555, 32'h5555_AAAA, '0, '0, '0, '0, '0, '0);
      pop_frame();
      pop_frame();
      pop_frame();
      wait_idle();
   endtask

   // Walk channel counts, including zero and values above the maximum
   task automatic test_channel_counts();
      logic [3:0] counts [6] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'd3};
      foreach (counts[i]) begin
         write_reg(CSR_NUM_CHANNELS, counts[i]);
         send_word(random_word(OP_PUSH));
         pop_frame();
         wait_idle();
      end
   endtask

   // Special float values through the int16 conversion
   task automatic test_int16_conversion();
      write_reg(CSR_OUTPUT_FORMAT, 4'd1);
      write_reg(CSR_NUM_CHANNELS, 4'd8);
      push_frame(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h3F00_0000, 32'h4000_0000, 32'hC000_0000, 32'h3F7F_FFFF);
      push_frame(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001,
                 32'h0000_0001, 32'h7F7F_FFFF, 32'hBF7F_FFFF, 32'h3F00_0001);
      push_frame(32'h3880_0000, 32'h3800_0100, 32'hB8FF_FFFF, 32'h3E99_999A,
                 32'h3F7F_FF00, 32'hBF7F_FFF0, 32'h007F_FFFF, 32'h3F55_5555);
      pop_frame();
      pop_frame();
      pop_frame();
      wait_idle();
      write_reg(CSR_OUTPUT_FORMAT, 4'd0);
   endtask

   // Change the frame size while samples are stored; the stream is re-framed
   task automatic test_count_change_with_data();
      write_reg(CSR_NUM_CHANNELS, 4'd2);
      repeat (3) send_word(random_word(OP_PUSH));
      wait_idle();
      write_reg(CSR_NUM_CHANNELS, 4'd3);
      pop_frame();
      pop_frame();
      pop_frame();
      wait_idle();
   endtask

   // Fill the ring behind a long receiver hold-off, overrun it, then drain
   task automatic test_overrun_fill();
      write_reg(CSR_NUM_CHANNELS, 4'd8);
      hold_asked++;
      gaps_on = 1'b0;
      while (drops_seen < 6) send_word(random_word(OP_PUSH));
      gaps_on = 1'b1;
      while (ring_used() >= frame_len()) pop_frame();
      pop_frame();
      wait_idle();
   endtask

   // Random phases of pushes and pops under random settings
   task automatic test_random_traffic();
      int          target;
      int          draw;
      logic [3:0]  nc_pick;
      req_word_type w;
      target = words_sent + 230;
      while (words_sent < target) begin
         draw = $urandom_range(0, 9);
         if (draw == 0) nc_pick = 4'($urandom_range(9, 15));
         else if (draw == 1) nc_pick = 4'd0;
         else nc_pick = 4'($urandom_range(1, 8));
         write_reg(CSR_NUM_CHANNELS, nc_pick);
         write_reg(CSR_OUTPUT_FORMAT, 4'($urandom_range(0, 1)));
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(15, 40)) begin
            w = random_word($urandom_range(0, 99) < 55 ? OP_PUSH : OP_POP);
            // Sprinkle exact conversion corner values into the samples
            if ($urandom_range(0, 3) == 0)
               w.sample_0 = 32'h3F80_0000 ^ 32'($urandom_range(0, 1)) << 31;
            send_word(w);
         end
         while (ring_used() >= frame_len()) pop_frame();
         gaps_on = 1'b1;
         stall_on = 1'b1;
         wait_idle();
      end
   endtask

   initial begin
      overrun_seen = 1'b0;
      written_total = '0;
      dropped_total = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      chan_reg = 4'd2;
      int16_mode = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      test_reset_state();
      test_channel_counts();
      test_int16_conversion();
      test_count_change_with_data();
      test_overrun_fill();
      test_random_traffic();
      wait_idle();
      $display("Covered %0d words and %0d results, %0d dropped frames,", words_sent,
               results_seen, drops_seen);
      $display("channel counts 0..15, float and int16 output, ring overrun and drain.");
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding", expected_rsp_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule
